### hdl/assert_macros.svh
// Assertion macros shared by the convolution engine RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### hdl/i8c2d_pkg.sv
// Shared types and codes for the int8 conv2d dot-product engine.
// No dependencies; used by the MAC unit and the top level.
package i8c2d_pkg;

	// Request kinds carried in s_tuser
	localparam logic [1:0] REQ_LOAD_ACT = 2'd0;
	localparam logic [1:0] REQ_LOAD_WGT = 2'd1;
	localparam logic [1:0] REQ_COMPUTE  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
	localparam logic [2:0] REG_IN_CHANNELS = 3'd2;
	localparam logic [2:0] REG_STRIDE_ROWS = 3'd3;
	localparam logic [2:0] REG_STRIDE_COLS = 3'd4;
	localparam logic [2:0] REG_PAD_ROWS    = 3'd5;
	localparam logic [2:0] REG_PAD_COLS    = 3'd6;
	localparam logic [2:0] REG_PAD_VALUE   = 3'd7;

	// Width of unsigned dimensions up to 256, and of signed tap positions
	localparam int DIM_W = 9;
	localparam int POS_W = 10;
	localparam int ACC_W = 32;

	// Controls from the sequencer to the MAC unit
	typedef struct packed {
		logic clr;
		logic en;
	} mac_ctl_t;

endpackage

### hdl/i8c2d_ram.sv
// Byte-wide simple dual-port store with registered read data.
// Standalone; instanced by the top level for activations and weights.
module i8c2d_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [7:0]   wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [7:0]   rdata
);

	logic signed [7:0] mem [DEPTH];
	logic signed [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/i8c2d_mac.sv
// Shared signed 8x8 multiply-accumulate unit with a registered product.
// Depends on i8c2d_pkg for the control struct and accumulator width.
module i8c2d_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  i8c2d_pkg::mac_ctl_t                 ctl,
	input  logic signed [7:0]                   a,
	input  logic signed [7:0]                   w,
	output logic signed [i8c2d_pkg::ACC_W-1:0]  acc,
	output logic                                busy
);

	logic signed [15:0]                  prod_s1;
	logic                                vld_s1;
	logic signed [i8c2d_pkg::ACC_W-1:0]  acc_q;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * w;
	end

	// accumulate, wraps at 32 bits
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + i8c2d_pkg::ACC_W'(prod_s1);
		end
	end

	assign acc  = acc_q;
	assign busy = vld_s1;

endmodule

### hdl/int8_conv2d_dot_engine.sv
// int8 conv2d dot engine: loads are written on accept; a compute item walks the K*K taps
// (K kernel size, C = min(in_channels, MAX_IN_CH)) through the TAP, BASE and MAC states on one shared MAC
// fed one tap-channel per cycle from the stores; with C = 0 or out_chan out of range it goes to DRAIN.
// From DRAIN, m_tdata takes the sum once the MAC pipeline is empty and the result side is free;
// one item in work at a time.
// Async reset loads register defaults and idles control; the stores are not cleared.
`include "assert_macros.svh"

module int8_conv2d_dot_engine #(
	parameter int MAX_ROWS    = 32,
	parameter int MAX_COLS    = 32,
	parameter int MAX_IN_CH   = 16,
	parameter int MAX_OUT_CH  = 32,
	parameter int KERNEL_SIZE = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] row, [9:5] col, [14:10] out_chan, [18:15] in_chan, [26:19] value, [31:27] zero
	input  logic [31:0] s_tdata,
	// [1:0] req_type
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] acc
	output logic [31:0] m_tdata
);

	localparam int DIM_W     = i8c2d_pkg::DIM_W;
	localparam int POS_W     = i8c2d_pkg::POS_W;
	localparam int ACC_W     = i8c2d_pkg::ACC_W;
	localparam int ACT_DEPTH = MAX_ROWS * MAX_COLS * MAX_IN_CH;
	localparam int WGT_DEPTH = MAX_OUT_CH * KERNEL_SIZE * KERNEL_SIZE * MAX_IN_CH;
	localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam int ROW_PITCH = MAX_COLS * MAX_IN_CH;
	localparam int OC_PITCH  = KERNEL_SIZE * KERNEL_SIZE * MAX_IN_CH;
	localparam int KW        = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
	localparam int IC_W      = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
	localparam int CH_W      = $clog2(MAX_IN_CH + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_TAP   = 5'b00010,
		S_BASE  = 5'b00100,
		S_MAC   = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

	// request fields
	logic [1:0]        req_type;
	logic [4:0]        f_row;
	logic [4:0]        f_col;
	logic [4:0]        f_out_chan;
	logic [3:0]        f_in_chan;
	logic signed [7:0] f_value;

	assign req_type   = s_tuser[1:0];
	assign f_row      = s_tdata[4:0];
	assign f_col      = s_tdata[9:5];
	assign f_out_chan = s_tdata[14:10];
	assign f_in_chan  = s_tdata[18:15];
	assign f_value    = s_tdata[26:19];

	// configuration registers
	logic [5:0]        in_height_q;
	logic [5:0]        in_width_q;
	logic [4:0]        in_channels_q;
	logic [2:0]        stride_rows_q;
	logic [2:0]        stride_cols_q;
	logic [1:0]        pad_rows_q;
	logic [1:0]        pad_cols_q;
	logic signed [7:0] pad_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= 6'd1;
			in_width_q    <= 6'd1;
			in_channels_q <= 5'd1;
			stride_rows_q <= 3'd1;
			stride_cols_q <= 3'd1;
			pad_rows_q    <= 2'd0;
			pad_cols_q    <= 2'd0;
			pad_value_q   <= 8'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i8c2d_pkg::REG_IN_HEIGHT:   in_height_q   <= cfg_data[5:0];
				i8c2d_pkg::REG_IN_WIDTH:    in_width_q    <= cfg_data[5:0];
				i8c2d_pkg::REG_IN_CHANNELS: in_channels_q <= cfg_data[4:0];
				i8c2d_pkg::REG_STRIDE_ROWS: stride_rows_q <= cfg_data[2:0];
				i8c2d_pkg::REG_STRIDE_COLS: stride_cols_q <= cfg_data[2:0];
				i8c2d_pkg::REG_PAD_ROWS:    pad_rows_q    <= cfg_data[1:0];
				i8c2d_pkg::REG_PAD_COLS:    pad_cols_q    <= cfg_data[1:0];
				i8c2d_pkg::REG_PAD_VALUE:   pad_value_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes clamped to the store dimensions
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] w_eff;
	logic [CH_W-1:0]  ch_eff;

	assign h_eff  = (DIM_W'(in_height_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
	                                                         : DIM_W'(in_height_q);
	assign w_eff  = (DIM_W'(in_width_q) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
	                                                        : DIM_W'(in_width_q);
	assign ch_eff = (DIM_W'(in_channels_q) > DIM_W'(MAX_IN_CH)) ? CH_W'(MAX_IN_CH)
	                                                            : CH_W'(in_channels_q);

	// sequencer state
	state_t                   state_q;
	logic [DIM_W-1:0]         rbase_q;
	logic [DIM_W-1:0]         cbase_q;
	logic [KW-1:0]            kh_q;
	logic [KW-1:0]            kw_q;
	logic [IC_W-1:0]          ic_q;
	logic signed [POS_W-1:0]  ih_q;
	logic signed [POS_W-1:0]  iw_q;
	logic                     inside_q;
	logic [ACT_AW-1:0]        act_ptr_q;
	logic [WGT_AW-1:0]        wgt_ptr_q;
	logic                     m_tvalid_q;
	logic [ACC_W-1:0]         acc_out_q;
	logic signed [ACC_W-1:0]  mac_acc;

	logic accept;
	logic is_compute;
	logic oc_ok;
	logic ic_last;
	logic kw_last;
	logic kh_last;
	logic out_free;
	logic drain_ok;
	logic mac_busy;
	logic rd_vld;
	logic rd_vld_s1;
	logic inside_s1;
	logic inside_c;

	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign is_compute = (req_type == i8c2d_pkg::REQ_COMPUTE);
	assign oc_ok      = DIM_W'(f_out_chan) < DIM_W'(MAX_OUT_CH);
	assign ic_last    = (CH_W'(ic_q) + CH_W'(1)) == ch_eff;
	assign kw_last    = (kw_q == KW'(KERNEL_SIZE - 1));
	assign kh_last    = (kh_q == KW'(KERNEL_SIZE - 1));
	assign out_free   = !m_tvalid_q || m_tready;
	assign drain_ok   = !rd_vld_s1 && !mac_busy && out_free;
	assign rd_vld     = (state_q == S_MAC);
	assign inside_c   = !ih_q[POS_W-1] && (ih_q[DIM_W-1:0] < h_eff)
	                 && !iw_q[POS_W-1] && (iw_q[DIM_W-1:0] < w_eff);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && is_compute) begin
						state_q <= (oc_ok && (ch_eff != '0)) ? S_TAP : S_DRAIN;
					end
				end
				S_TAP:  state_q <= S_BASE;
				S_BASE: state_q <= S_MAC;
				S_MAC: begin
					if (ic_last) begin
						state_q <= (kw_last && kh_last) ? S_DRAIN : S_TAP;
					end
				end
				S_DRAIN: begin
					if (drain_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result valid: set when the sum is handed over, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DRAIN) && drain_ok) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// counters, tap positions and store pointers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rbase_q   <= DIM_W'(DIM_W'(f_row) * DIM_W'(stride_rows_q));
				cbase_q   <= DIM_W'(DIM_W'(f_col) * DIM_W'(stride_cols_q));
				kh_q      <= '0;
				kw_q      <= '0;
				wgt_ptr_q <= WGT_AW'(WGT_AW'(f_out_chan) * WGT_AW'(OC_PITCH));
			end
			S_TAP: begin
				ih_q <= $signed(POS_W'(rbase_q) + POS_W'(kh_q) - POS_W'(pad_rows_q));
				iw_q <= $signed(POS_W'(cbase_q) + POS_W'(kw_q) - POS_W'(pad_cols_q));
			end
			S_BASE: begin
				inside_q  <= inside_c;
				act_ptr_q <= inside_c
					? ACT_AW'(ACT_AW'(ih_q[DIM_W-1:0]) * ACT_AW'(ROW_PITCH)
					        + ACT_AW'(iw_q[DIM_W-1:0]) * ACT_AW'(MAX_IN_CH))
					: '0;
				ic_q      <= '0;
			end
			S_MAC: begin
				ic_q <= ic_q + IC_W'(1);
				if (ic_last) begin
					wgt_ptr_q <= wgt_ptr_q + WGT_AW'(MAX_IN_CH);
					if (kw_last) begin
						kw_q <= '0;
						kh_q <= kh_q + KW'(1);
					end else begin
						kw_q <= kw_q + KW'(1);
					end
				end
			end
			S_DRAIN: begin
				if (drain_ok) begin
					acc_out_q <= mac_acc;
				end
			end
			default: ;
		endcase
	end

	// load decode
	logic              act_we;
	logic              wgt_we;
	logic [ACT_AW-1:0] act_waddr;
	logic [WGT_AW-1:0] wgt_waddr;

	assign act_we = accept && (req_type == i8c2d_pkg::REQ_LOAD_ACT)
	             && (DIM_W'(f_row) < DIM_W'(MAX_ROWS))
	             && (DIM_W'(f_col) < DIM_W'(MAX_COLS))
	             && (DIM_W'(f_in_chan) < DIM_W'(MAX_IN_CH));
	assign wgt_we = accept && (req_type == i8c2d_pkg::REQ_LOAD_WGT)
	             && (DIM_W'(f_row) < DIM_W'(KERNEL_SIZE))
	             && (DIM_W'(f_col) < DIM_W'(KERNEL_SIZE))
	             && oc_ok
	             && (DIM_W'(f_in_chan) < DIM_W'(MAX_IN_CH));

	assign act_waddr = ACT_AW'((ACT_AW'(f_row) * ACT_AW'(MAX_COLS) + ACT_AW'(f_col))
	                           * ACT_AW'(MAX_IN_CH) + ACT_AW'(f_in_chan));
	assign wgt_waddr = WGT_AW'(((WGT_AW'(f_out_chan) * WGT_AW'(KERNEL_SIZE) + WGT_AW'(f_row))
	                            * WGT_AW'(KERNEL_SIZE) + WGT_AW'(f_col)) * WGT_AW'(MAX_IN_CH)
	                           + WGT_AW'(f_in_chan));

	// stores
	logic signed [7:0] act_rdata;
	logic signed [7:0] wgt_rdata;

	i8c2d_ram #(
		.DEPTH (ACT_DEPTH),
		.AW    (ACT_AW)
	) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (f_value),
		.raddr (act_ptr_q + ACT_AW'(ic_q)),
		.rdata (act_rdata)
	);

	i8c2d_ram #(
		.DEPTH (WGT_DEPTH),
		.AW    (WGT_AW)
	) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (f_value),
		.raddr (wgt_ptr_q + WGT_AW'(ic_q)),
		.rdata (wgt_rdata)
	);

	// read stage tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_vld;
		end
	end

	always_ff @(posedge clk) begin
		inside_s1 <= inside_q;
	end

	// shared multiply-accumulate
	i8c2d_pkg::mac_ctl_t mac_ctl;

	assign mac_ctl = '{clr: accept && is_compute, en: rd_vld_s1};

	i8c2d_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (inside_s1 ? act_rdata : pad_value_q),
		.w      (wgt_rdata),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = acc_out_q;

	// checks
	`ASSERT_CLK(a_idle_pipe_empty, s_tready |-> (!rd_vld_s1 && !mac_busy),
		"request taken while MAC pipeline still busy")
	`ASSERT_CLK(a_ic_in_range, (state_q == S_MAC) |-> (CH_W'(ic_q) < ch_eff),
		"channel counter ran past configured channel count")
	`ASSERT_NEVER(a_no_load_in_work, (act_we || wgt_we) && (state_q != S_IDLE),
		"store written while a compute is in progress")

endmodule

### test/int8_conv2d_dot_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for int8_conv2d_dot_engine: loads and compute items with random gaps,
// output stalls and register settings. Depends on i8c2d_pkg and the engine RTL.
module int8_conv2d_dot_engine_tb;

	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int MAX_IN_CH   = 16;
	localparam int MAX_OUT_CH  = 32;
	localparam int KSIZE       = 3;
	localparam int ACT_DEPTH   = MAX_ROWS * MAX_COLS * MAX_IN_CH;
	localparam int WGT_DEPTH   = MAX_OUT_CH * KSIZE * KSIZE * MAX_IN_CH;
	// req_type 3 is not a request; the engine drops it
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// compute latency at full channel count plus margin
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 150;

	// Mirror of the engine: stores, registers and expected sums in arrival order
	class conv_dot_tracker;
		bit signed [7:0] act_mem [ACT_DEPTH];
		bit signed [7:0] wgt_mem [WGT_DEPTH];
		bit act_set [ACT_DEPTH];
		bit wgt_set [WGT_DEPTH];
		bit [5:0] height, width;
		bit [4:0] chans;
		bit [2:0] step_r, step_c;
		bit [1:0] pad_r, pad_c;
		bit signed [7:0] pad_val;
		int pending_acc [$];
		int errors;

		function new();
			height = 1;
			width = 1;
			chans = 1;
			step_r = 1;
			step_c = 1;
			pad_r = 0;
			pad_c = 0;
			pad_val = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] data);
			case (idx)
				i8c2d_pkg::REG_IN_HEIGHT:   height = data[5:0];
				i8c2d_pkg::REG_IN_WIDTH:    width = data[5:0];
				i8c2d_pkg::REG_IN_CHANNELS: chans = data[4:0];
				i8c2d_pkg::REG_STRIDE_ROWS: step_r = data[2:0];
				i8c2d_pkg::REG_STRIDE_COLS: step_c = data[2:0];
				i8c2d_pkg::REG_PAD_ROWS:    pad_r = data[1:0];
				i8c2d_pkg::REG_PAD_COLS:    pad_c = data[1:0];
				default:                    pad_val = data;
			endcase
		endfunction

		// sizes clamp at the store dimensions
		function int rows_used();
			return int'(height) > MAX_ROWS ? MAX_ROWS : int'(height);
		endfunction

		function int cols_used();
			return int'(width) > MAX_COLS ? MAX_COLS : int'(width);
		endfunction

		function int chans_used();
			return int'(chans) > MAX_IN_CH ? MAX_IN_CH : int'(chans);
		endfunction

		// activation base address of one tap, -1 when the tap falls in the padding
		function int tap_addr(int orow, int ocol, int kh, int kw);
			int ih, iw;
			ih = orow * int'(step_r) + kh - int'(pad_r);
			iw = ocol * int'(step_c) + kw - int'(pad_c);
			if (ih < 0 || ih >= rows_used() || iw < 0 || iw >= cols_used())
				return -1;
			return (ih * MAX_COLS + iw) * MAX_IN_CH;
		endfunction

		function int wgt_addr(int oc, int kh, int kw, int ic);
			return ((oc * KSIZE + kh) * KSIZE + kw) * MAX_IN_CH + ic;
		endfunction

		function int window_sum(int orow, int ocol, int oc);
			int sum, base, a;
			sum = 0;
			for (int kh = 0; kh < KSIZE; kh++) begin
				for (int kw = 0; kw < KSIZE; kw++) begin
					base = tap_addr(orow, ocol, kh, kw);
					for (int ic = 0; ic < chans_used(); ic++) begin
						a = base < 0 ? int'(pad_val) : int'(act_mem[base + ic]);
						sum += a * int'(wgt_mem[wgt_addr(oc, kh, kw, ic)]);
					end
				end
			end
			return sum;
		endfunction

		function void take_request(logic [1:0] req, logic [4:0] row, logic [4:0] col,
				logic [4:0] oc, logic [3:0] ic, logic [7:0] val);
			int addr;
			case (req)
				i8c2d_pkg::REQ_LOAD_ACT: begin
					addr = (int'(row) * MAX_COLS + int'(col)) * MAX_IN_CH + int'(ic);
					act_mem[addr] = val;
					act_set[addr] = 1'b1;
				end
				i8c2d_pkg::REQ_LOAD_WGT: begin
					// taps beyond the kernel are dropped
					if (int'(row) < KSIZE && int'(col) < KSIZE) begin
						addr = wgt_addr(int'(oc), int'(row), int'(col), int'(ic));
						wgt_mem[addr] = val;
						wgt_set[addr] = 1'b1;
					end
				end
				i8c2d_pkg::REQ_COMPUTE:
					pending_acc.push_back(window_sum(int'(row), int'(col), int'(oc)));
				default: ;
			endcase
		endfunction

		function void match_acc(logic [31:0] got);
			int want;
			if (pending_acc.size() == 0) begin
				$display("%0t: acc %0d arrived with nothing expected", $time, $signed(got));
				errors++;
				return;
			end
			want = pending_acc.pop_front();
			if ($signed(got) != want) begin
				$display("%0t: acc mismatch: expected %0d, got %0d", $time, want, $signed(got));
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	// [4:0] row, [9:5] col, [14:10] out_chan, [18:15] in_chan, [26:19] value, [31:27] zero
	logic [31:0] s_tdata;
	// [1:0] req_type
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [31:0] acc
	logic [31:0] m_tdata;

	conv_dot_tracker board = new();
	bit quiet = 1'b0;
	int useful_items = 0;
	int fav_oc [4];

	int8_conv2d_dot_engine #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.MAX_IN_CH(MAX_IN_CH),
		.MAX_OUT_CH(MAX_OUT_CH),
		.KERNEL_SIZE(KSIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Idle stretch: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'h80;
		if (r == 1)
			return 8'h7F;
		return 8'($urandom);
	endfunction

	// Output position near the input area most of the time, anywhere otherwise
	function automatic int pick_out_pos(int size, int stride, int pad);
		int span;
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 31);
		span = (size + pad) / (stride == 0 ? 1 : stride);
		return $urandom_range(0, span > 31 ? 31 : span);
	endfunction

	// Result side: ready runs and stalls
	initial begin
		int hold;
		bit level;
		m_tready = 1'b0;
		hold = 0;
		level = 1'b0;
		forever begin
			if (hold == 0) begin
				level = quiet || ($urandom_range(0, 99) < 60);
				hold = level ? $urandom_range(1, 30) : idle_len();
			end
			@(negedge clk);
			m_tready <= quiet ? 1'b1 : level;
			hold--;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.match_acc(m_tdata);
	end

	task automatic send_item(logic [1:0] req, logic [4:0] row, logic [4:0] col,
			logic [4:0] oc, logic [3:0] ic, logic [7:0] val);
		int gap;
		gap = quiet ? 0 : (($urandom_range(0, 1) == 0) ? 0 : idle_len());
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {5'b0, val, ic, oc, col, row};
		do @(posedge clk); while (!s_tready);
		board.take_request(req, row, col, oc, ic, val);
		if (!(req == REQ_UNUSED || (req == i8c2d_pkg::REQ_LOAD_WGT && (int'(row) >= KSIZE
				|| int'(col) >= KSIZE))))
			useful_items++;
	endtask

	// Stop sending until every sum is back; optionally let the engine go quiet after
	task automatic settle(bit with_tail);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending_acc.size() != 0) @(negedge clk);
		if (with_tail)
			repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		board.write_reg(idx, data);
	endtask

	// Write every register, sometimes with junk in the unused upper bits
	task automatic apply_settings(int h, int w, int ch, int sr, int sc, int pr, int pc, int pv);
		logic [7:0] junk;
		junk = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
		set_reg(i8c2d_pkg::REG_IN_HEIGHT, (junk & 8'hC0) | 8'(h & 'h3F));
		set_reg(i8c2d_pkg::REG_IN_WIDTH, (junk & 8'hC0) | 8'(w & 'h3F));
		set_reg(i8c2d_pkg::REG_IN_CHANNELS, (junk & 8'hE0) | 8'(ch & 'h1F));
		set_reg(i8c2d_pkg::REG_STRIDE_ROWS, (junk & 8'hF8) | 8'(sr & 'h7));
		set_reg(i8c2d_pkg::REG_STRIDE_COLS, (junk & 8'hF8) | 8'(sc & 'h7));
		set_reg(i8c2d_pkg::REG_PAD_ROWS, (junk & 8'hFC) | 8'(pr & 'h3));
		set_reg(i8c2d_pkg::REG_PAD_COLS, (junk & 8'hFC) | 8'(pc & 'h3));
		set_reg(i8c2d_pkg::REG_PAD_VALUE, 8'(pv));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Load every store byte a compute will read that has not been written yet
	task automatic fill_window(int orow, int ocol, int oc);
		int base, kh, kw, ic;
		for (kh = 0; kh < KSIZE; kh++) begin
			for (kw = 0; kw < KSIZE; kw++) begin
				base = board.tap_addr(orow, ocol, kh, kw);
				for (ic = 0; ic < board.chans_used(); ic++) begin
					if (!board.wgt_set[board.wgt_addr(oc, kh, kw, ic)])
						send_item(i8c2d_pkg::REQ_LOAD_WGT, 5'(kh), 5'(kw), 5'(oc), 4'(ic),
							rand_byte());
					if (base >= 0 && !board.act_set[base + ic])
						send_item(i8c2d_pkg::REQ_LOAD_ACT, 5'(base / (MAX_COLS * MAX_IN_CH)),
							5'((base / MAX_IN_CH) % MAX_COLS), 5'($urandom), 4'(ic),
							rand_byte());
				end
			end
		end
	endtask

	task automatic random_item();
		int r, row, col, oc, ic;
		r = $urandom_range(0, 99);
		ic = board.chans_used() > 0 ? $urandom_range(0, board.chans_used() - 1)
			: $urandom_range(0, 15);
		if (r < 1) begin
			settle(1'b0);
		end else if (r < 36) begin
			row = pick_out_pos(board.rows_used(), int'(board.step_r), int'(board.pad_r));
			col = pick_out_pos(board.cols_used(), int'(board.step_c), int'(board.pad_c));
			oc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
				: fav_oc[$urandom_range(0, 3)];
			fill_window(row, col, oc);
			send_item(i8c2d_pkg::REQ_COMPUTE, 5'(row), 5'(col), 5'(oc), 4'($urandom),
				8'($urandom));
		end else if (r < 60) begin
			// overwrite activations inside the window area, or anywhere
			row = (board.rows_used() == 0 || $urandom_range(0, 9) == 0)
				? $urandom_range(0, 31) : $urandom_range(0, board.rows_used() - 1);
			col = (board.cols_used() == 0 || $urandom_range(0, 9) == 0)
				? $urandom_range(0, 31) : $urandom_range(0, board.cols_used() - 1);
			if ($urandom_range(0, 9) == 0)
				ic = $urandom_range(0, 15);
			send_item(i8c2d_pkg::REQ_LOAD_ACT, 5'(row), 5'(col), 5'($urandom), 4'(ic),
				rand_byte());
		end else if (r < 90) begin
			oc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
				: fav_oc[$urandom_range(0, 3)];
			send_item(i8c2d_pkg::REQ_LOAD_WGT, 5'($urandom_range(0, KSIZE - 1)),
				5'($urandom_range(0, KSIZE - 1)), 5'(oc), 4'(ic), rand_byte());
		end else if (r < 95) begin
			send_item(REQ_UNUSED, 5'($urandom), 5'($urandom), 5'($urandom), 4'($urandom),
				8'($urandom));
		end else begin
			// weight tap outside the kernel, dropped by the engine
			row = $urandom_range(0, 31);
			col = (row < KSIZE) ? $urandom_range(KSIZE, 31) : $urandom_range(0, 31);
			send_item(i8c2d_pkg::REQ_LOAD_WGT, 5'(row), 5'(col), 5'($urandom), 4'($urandom),
				rand_byte());
		end
	endtask

	task automatic run_phase(int h, int w, int ch, int sr, int sc, int pr, int pc, int pv);
		int start;
		settle(1'b1);
		apply_settings(h, w, ch, sr, sc, pr, pc, pv);
		quiet = ($urandom_range(0, 3) == 0);
		foreach (fav_oc[i])
			fav_oc[i] = $urandom_range(0, 31);
		start = useful_items;
		while (useful_items - start < PHASE_ITEMS)
			random_item();
	endtask

	// Mostly small maps and few channels, now and then odd or oversized values
	function automatic int rand_size(int top, int full);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, top);
		if (r < 95)
			return $urandom_range(1, full);
		return $urandom_range(0, 1) == 0 ? 0 : $urandom_range(full + 1, 2 * full - 1);
	endfunction

	function automatic int rand_stride();
		return $urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(0, 7);
	endfunction

	// Directed opening under reset settings: one in-range tap, dropped items, all-pad window
	task automatic directed_items();
		int kh, kw;
		send_item(i8c2d_pkg::REQ_LOAD_ACT, 5'd0, 5'd0, 5'd0, 4'd0, 8'h80);
		for (kh = 0; kh < KSIZE; kh++)
			for (kw = 0; kw < KSIZE; kw++)
				send_item(i8c2d_pkg::REQ_LOAD_WGT, 5'(kh), 5'(kw), 5'd31, 4'd0,
					(kh == 0 && kw == 0) ? 8'h80 : 8'h7F);
		send_item(i8c2d_pkg::REQ_COMPUTE, 5'd0, 5'd0, 5'd31, 4'd0, 8'h00);
		send_item(i8c2d_pkg::REQ_LOAD_WGT, 5'd3, 5'd0, 5'd31, 4'd0, 8'h05);
		send_item(i8c2d_pkg::REQ_LOAD_WGT, 5'd0, 5'd31, 5'd31, 4'd15, 8'h7F);
		send_item(REQ_UNUSED, 5'd31, 5'd31, 5'd31, 4'd15, 8'hFF);
		send_item(i8c2d_pkg::REQ_COMPUTE, 5'd0, 5'd0, 5'd31, 4'd15, 8'hFF);
		send_item(i8c2d_pkg::REQ_COMPUTE, 5'd31, 5'd31, 5'd31, 4'd0, 8'h00);
		send_item(i8c2d_pkg::REQ_LOAD_ACT, 5'd31, 5'd31, 5'd31, 4'd15, 8'h7F);
		send_item(i8c2d_pkg::REQ_COMPUTE, 5'd0, 5'd0, 5'd31, 4'd0, 8'h00);
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = i8c2d_pkg::REQ_LOAD_ACT;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_items();
		// largest map, stride 4, widest padding, most negative pad
		run_phase(32, 32, 16, 4, 4, 3, 3, -128);
		// smallest legal settings
		run_phase(1, 1, 1, 1, 1, 0, 0, 127);
		// zero height, zero channels, zero row stride
		run_phase(0, 5, 0, 0, 2, 1, 2, -1);
		// oversized sizes saturate, stride 7, zero column stride
		run_phase(63, 40, 31, 7, 0, 2, 1, 1);
		repeat (8)
			run_phase(rand_size(6, 32), rand_size(6, 32), rand_size(4, 16), rand_stride(),
				rand_stride(), $urandom_range(0, 3), $urandom_range(0, 3),
				$signed(8'($urandom)));
		settle(1'b1);

		if (board.errors == 0)
			$display("PASS int8_conv2d_dot_engine");
		else
			$display("FAIL int8_conv2d_dot_engine");
		$finish;
	end

	// Hang guard
	initial begin
		#(60_000_000);
		$display("FAIL int8_conv2d_dot_engine");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/i8c2d_pkg.sv
hdl/i8c2d_ram.sv
hdl/i8c2d_mac.sv
hdl/int8_conv2d_dot_engine.sv
test/int8_conv2d_dot_engine_tb.sv
